/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Operation codes, the command record passed from the front end to the
// back end, and the back end state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Field widths fixed by the port list.
  localparam int CELL_W      = 16;
  localparam int CHAR_W      = 8;
  localparam int COLOUR_W    = 8;
  localparam int CUR_COL_W   = 7;
  localparam int CUR_LINE_W  = 5;

  // Address width that covers up to 256 x 128 cells.
  localparam int CELL_ADDR_W = 15;

  // Character and colour constants.
  localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'd32;
  localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'd15;

  // Operation codes on the operation port.
  typedef enum logic [1:0] {
    OP_PUT_CURSOR = 2'd0,
    OP_PUT_POS    = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  // One classified command, ready for the memory side to carry out.
  typedef struct packed {
    logic                   do_write;
    logic                   do_scroll;
    logic                   do_clear;
    logic                   do_read;
    logic [CELL_ADDR_W-1:0] addr;
    logic [CELL_W-1:0]      cell_word;
    logic [CUR_COL_W-1:0]   cursor_col;
    logic [CUR_LINE_W-1:0]  cursor_line;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_READ_WAIT,
    BK_COPY,
    BK_DRAIN,
    BK_FILL,
    BK_REPORT
  } back_state_t;

endpackage

/* rtl/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front: command front end
// Accepts operations, tracks the cursor, and turns each operation into a
// command record for the memory side.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            operation,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [COLOUR_W-1:0]   colour,
  input  logic [CUR_COL_W-1:0]  column,
  input  logic [CUR_LINE_W-1:0] row,
  output logic                  push,
  output cmd_t                  cmd
);

  localparam int XW = $clog2(COLUMNS);
  localparam int YW = $clog2(ROWS);
  localparam logic [XW-1:0] LAST_COL   = XW'(COLUMNS - 1);
  localparam logic [YW-1:0] BOTTOM_ROW = YW'(ROWS - 1);
  localparam logic [YW-1:0] SCROLL_ROW = YW'(ROWS - 2);
  localparam logic [8:0]    COL_LIMIT  = 9'(COLUMNS);
  localparam logic [7:0]    ROW_LIMIT  = 8'(ROWS);

  logic [XW-1:0] cursor_x;
  logic [XW-1:0] cursor_x_next;
  logic [YW-1:0] cursor_y;
  logic [YW-1:0] cursor_y_next;
  logic [YW-1:0] cursor_y_adv;
  logic          pos_ok;
  logic [CELL_ADDR_W-1:0] cursor_addr;
  logic [CELL_ADDR_W-1:0] pos_addr;
  op_t           op;

  // An operation is taken whenever the block is not busy.
  assign push = start && !busy;
  assign op   = op_t'(operation);

  // Cell addresses for the cursor and for an explicit position.
  assign cursor_addr = CELL_ADDR_W'(cursor_y) * CELL_ADDR_W'(COLUMNS)
                     + CELL_ADDR_W'(cursor_x);
  assign pos_addr    = CELL_ADDR_W'(row) * CELL_ADDR_W'(COLUMNS)
                     + CELL_ADDR_W'(column);
  assign pos_ok      = (9'(column) < COL_LIMIT) && (8'(row) < ROW_LIMIT);

  // Classify the operation and work out the new cursor.
  always_comb begin
    cursor_x_next  = cursor_x;
    cursor_y_next  = cursor_y;
    cursor_y_adv   = cursor_y;
    cmd.do_write   = 1'b0;
    cmd.do_scroll  = 1'b0;
    cmd.do_clear   = 1'b0;
    cmd.do_read    = 1'b0;
    cmd.addr       = pos_addr;
    cmd.cell_word  = {colour, char_code};
    case (op)
      OP_PUT_CURSOR: begin
        if (char_code == NEWLINE_CODE) begin
          cursor_x_next = '0;
          cursor_y_adv  = cursor_y + YW'(1);
        end else begin
          cmd.do_write = 1'b1;
          cmd.addr     = cursor_addr;
          if (cursor_x == LAST_COL) begin
            cursor_x_next = '0;
            cursor_y_adv  = cursor_y + YW'(1);
          end else begin
            cursor_x_next = cursor_x + XW'(1);
          end
        end
        // Reaching the bottom row scrolls the screen up by one row.
        if (cursor_y_adv == BOTTOM_ROW) begin
          cmd.do_scroll = 1'b1;
          cursor_y_next = SCROLL_ROW;
        end else begin
          cursor_y_next = cursor_y_adv;
        end
      end
      OP_PUT_POS: begin
        cmd.do_write = pos_ok;
      end
      OP_CLEAR: begin
        cmd.do_clear  = 1'b1;
        cursor_x_next = '0;
        cursor_y_next = '0;
      end
      OP_READ: begin
        cmd.do_read = pos_ok;
      end
      default: begin
        cmd.do_write = 1'b0;
      end
    endcase
    cmd.cursor_col  = CUR_COL_W'(cursor_x_next);
    cmd.cursor_line = CUR_LINE_W'(cursor_y_next);
  end

  // Cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (push) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
    end
  end

endmodule

/* rtl/tcw_queue.sv */
// ----------------------------------------------------------------------------
// tcw_queue: two-entry command queue
// Decouples the front end from the memory sequencer so each can stall
// on its own.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic valid,
  output logic full,
  output cmd_t head
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  cmd_t            entries [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     count;

  assign valid = (count != '0);
  assign full  = (count == (PW+1)'(DEPTH));
  assign head  = entries[rptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

endmodule

/* rtl/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back: screen memory sequencer
// Owns the cell store and carries out writes, reads, scroll copies and
// fill sweeps one command at a time, then reports each beat.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  input  logic                  cfg_write_en,
  input  logic [COLOUR_W-1:0]   cfg_write_data,
  output logic                  init_busy,
  output logic                  done,
  output logic [CELL_W-1:0]     cell_value,
  output logic [CUR_COL_W-1:0]  cursor_col,
  output logic [CUR_LINE_W-1:0] cursor_line,
  output logic                  scrolled
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELL_COUNT - COLUMNS);

  back_state_t         state;
  back_state_t         state_next;
  cmd_t                cmd_q;
  logic [ADDR_W-1:0]   ptr;
  logic                init_q;
  logic                copy_pend;
  logic [ADDR_W-1:0]   copy_waddr;
  logic [CELL_W-1:0]   fill_cell;
  logic [COLOUR_W-1:0] default_colour;
  logic [CELL_W-1:0]   cell_q;

  logic [CELL_W-1:0]   mem [CELL_COUNT];
  logic [CELL_W-1:0]   mem_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (cmd_q.do_clear) begin
          state_next = BK_FILL;
        end else if (cmd_q.do_scroll) begin
          state_next = BK_COPY;
        end else if (cmd_q.do_read) begin
          state_next = BK_READ_WAIT;
        end else begin
          state_next = BK_REPORT;
        end
      end
      BK_READ_WAIT: begin
        state_next = BK_REPORT;
      end
      BK_COPY: begin
        if (ptr == LAST_ADDR) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        state_next = BK_FILL;
      end
      BK_FILL: begin
        if (ptr == LAST_ADDR) begin
          state_next = init_q ? BK_IDLE : BK_REPORT;
        end
      end
      BK_REPORT: begin
        state_next = q_valid ? BK_EXEC : BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Memory port control and queue pop.
  always_comb begin
    q_pop     = q_valid && ((state == BK_IDLE) || (state == BK_REPORT));
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = fill_cell;
    mem_raddr = ptr;
    case (state)
      BK_EXEC: begin
        mem_we    = cmd_q.do_write;
        mem_waddr = cmd_q.addr[ADDR_W-1:0];
        mem_wdata = cmd_q.cell_word;
        mem_raddr = cmd_q.addr[ADDR_W-1:0];
      end
      BK_COPY: begin
        // Read one row ahead, write the previous read back one row up.
        mem_we    = copy_pend;
        mem_waddr = copy_waddr;
        mem_wdata = mem_q;
      end
      BK_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = copy_waddr;
        mem_wdata = mem_q;
      end
      BK_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_FILL;
      ptr            <= '0;
      init_q         <= 1'b1;
      copy_pend      <= 1'b0;
      fill_cell      <= {RESET_COLOUR, SPACE_CODE};
      default_colour <= RESET_COLOUR;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        default_colour <= cfg_write_data;
      end
      case (state)
        BK_EXEC: begin
          ptr       <= cmd_q.do_clear ? '0 : ROW_STRIDE;
          fill_cell <= {default_colour, SPACE_CODE};
          copy_pend <= 1'b0;
        end
        BK_COPY: begin
          ptr       <= ptr + ADDR_W'(1);
          copy_pend <= 1'b1;
        end
        BK_DRAIN: begin
          ptr <= BOTTOM_BASE;
        end
        BK_FILL: begin
          ptr <= ptr + ADDR_W'(1);
          if (ptr == LAST_ADDR) begin
            init_q <= 1'b0;
          end
        end
        default: begin
          ptr <= ptr;
        end
      endcase
    end
  end

  // Payload registers: current command, copy address and read result.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_q <= q_cmd;
    end
    if (state == BK_COPY) begin
      copy_waddr <= ptr - ROW_STRIDE;
    end
    if (state == BK_EXEC) begin
      cell_q <= '0;
    end else if (state == BK_READ_WAIT) begin
      cell_q <= mem_q;
    end
  end

  // Cell store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  // Result beat.
  assign init_busy   = init_q;
  assign done        = (state == BK_REPORT);
  assign cell_value  = cell_q;
  assign cursor_col  = cmd_q.cursor_col;
  assign cursor_line = cmd_q.cursor_line;
  assign scrolled    = cmd_q.do_scroll;

endmodule

/* rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer: text screen store with cursor
// Character cell store with put, positioned put, clear, read and scroll.
// ----------------------------------------------------------------------------
// Usage:
//   An operation is taken on a rising edge where start is high and busy is
//   low. Each operation produces one result beat: done is high for exactly
//   one cycle with cell_value, cursor_col, cursor_line and scrolled valid.
//   The receiver cannot stall; results must be captured when done is high.
//   The default_colour register is written through cfg_write_en and
//   cfg_write_data. The user must write it only while the block is idle;
//   the block itself does not enforce this.
//   A scroll copies every row below the top one row up, passes through
//   one drain step, then sweeps the bottom row; a clear sweeps the whole
//   store. A two-entry command queue lets up to two operations wait
//   while a sweep runs.
//   After reset, busy stays high while the store is swept to spaces in
//   colour 15, and the cursor is home.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [COLOUR_W-1:0]   colour,
  input  logic [CUR_COL_W-1:0]  column,
  input  logic [CUR_LINE_W-1:0] row,
  input  logic                  cfg_write_en,
  input  logic [COLOUR_W-1:0]   cfg_write_data,
  output logic                  done,
  output logic [CELL_W-1:0]     cell_value,
  output logic [CUR_COL_W-1:0]  cursor_col,
  output logic [CUR_LINE_W-1:0] cursor_line,
  output logic                  scrolled
);

  logic push;
  cmd_t push_cmd;
  logic q_valid;
  logic q_full;
  cmd_t q_head;
  logic q_pop;
  logic init_busy;

  // Hold off new operations while the queue is full or the store is swept after reset.
  assign busy = q_full || init_busy;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .char_code (char_code),
    .colour    (colour),
    .column    (column),
    .row       (row),
    .push      (push),
    .cmd       (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (q_head)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_head),
    .q_pop          (q_pop),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .init_busy      (init_busy),
    .done           (done),
    .cell_value     (cell_value),
    .cursor_col     (cursor_col),
    .cursor_line    (cursor_line),
    .scrolled       (scrolled)
  );

endmodule

/* rtl/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Watches the top level ports and flags impossible result beats.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  busy,
  input logic                  done,
  input logic [CELL_W-1:0]     cell_value,
  input logic [CUR_COL_W-1:0]  cursor_col,
  input logic [CUR_LINE_W-1:0] cursor_line,
  input logic                  scrolled
);

  // The store is swept after reset, so no operation is taken at once.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // No result beat can follow reset directly.
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");

  // A scroll always leaves the cursor on the second to last row.
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (done && scrolled) |-> (cursor_line == CUR_LINE_W'(ROWS - 2)))
    else $error("scroll left cursor on wrong row");

  // Only a put at the cursor scrolls, and it returns no cell.
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (rst)
    (done && scrolled) |-> (cell_value == '0))
    else $error("scroll beat carried a cell value");

  // The reported cursor stays on the screen and never reaches the bottom row.
  a_cursor_row_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (({3'b000, cursor_line} < 8'(ROWS - 1)) &&
              ({2'b00, cursor_col} < 9'(COLUMNS))))
    else $error("cursor out of range");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .done        (done),
  .cell_value  (cell_value),
  .cursor_col  (cursor_col),
  .cursor_line (cursor_line),
  .scrolled    (scrolled)
);

/* dv/console_screen_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_screen_checker: result checker for the text console writer
// Watches the command, register and result ports. It keeps its own copy of
// the screen, the cursor and the blank colour, predicts one report per
// accepted command, and compares every result beat with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module console_screen_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            operation,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic [COLOUR_W-1:0]   colour,
  input  logic [CUR_COL_W-1:0]  column,
  input  logic [CUR_LINE_W-1:0] row,
  input  logic                  cfg_write_en,
  input  logic [COLOUR_W-1:0]   cfg_write_data,
  input  logic                  done,
  input  logic [CELL_W-1:0]     cell_value,
  input  logic [CUR_COL_W-1:0]  cursor_col,
  input  logic [CUR_LINE_W-1:0] cursor_line,
  input  logic                  scrolled,
  output int                    fail_count,
  output int                    pending,
  output int                    scroll_count
);

  localparam int CELLS = ROWS * COLUMNS;

  // One predicted report: the read cell, the cursor after the command and the scroll flag.
  typedef struct packed {
    logic [CELL_W-1:0]     cell_word;
    logic [CUR_COL_W-1:0]  col;
    logic [CUR_LINE_W-1:0] line;
    logic                  scr;
  } cursor_report_t;

  // Shadow copy of the screen state.
  logic [CELL_W-1:0]   screen [CELLS];
  int                  cur_x;
  int                  cur_y;
  logic [COLOUR_W-1:0] blank_colour;

  cursor_report_t predicted_reports[$];
  int             mismatches;
  int             scrolls_seen;

  initial begin
    mismatches   = 0;
    scrolls_seen = 0;
  end

  // Fill every cell with a space in the current blank colour.
  function automatic void wipe_screen();
    int i;
    for (i = 0; i < CELLS; i++) begin
      screen[i] = {blank_colour, SPACE_CODE};
    end
  endfunction

  // Once the cursor sits on the bottom row, move every row up by one and
  // blank the bottom row. Returns 1 when that happened.
  function automatic logic scroll_if_bottom();
    int i;
    if (cur_y + 1 != ROWS) begin
      return 1'b0;
    end
    for (i = COLUMNS; i < CELLS; i++) begin
      screen[i - COLUMNS] = screen[i];
    end
    for (i = CELLS - COLUMNS; i < CELLS; i++) begin
      screen[i] = {blank_colour, SPACE_CODE};
    end
    cur_y = ROWS - 2;
    return 1'b1;
  endfunction

  // Carry out one command on the shadow screen and build its report.
  function automatic cursor_report_t run_command(
    input op_t                   op,
    input logic [CHAR_W-1:0]     ch,
    input logic [COLOUR_W-1:0]   attr,
    input logic [CUR_COL_W-1:0]  col,
    input logic [CUR_LINE_W-1:0] rw
  );
    cursor_report_t r;
    r = '0;
    case (op)
      OP_PUT_CURSOR: begin
        if (ch == NEWLINE_CODE) begin
          cur_y++;
          cur_x = 0;
        end else begin
          screen[cur_y * COLUMNS + cur_x] = {attr, ch};
          cur_x++;
          if (cur_x >= COLUMNS) begin
            cur_x = 0;
            cur_y++;
          end
        end
        r.scr = scroll_if_bottom();
      end
      OP_PUT_POS: begin
        if (col < COLUMNS && rw < ROWS) begin
          screen[rw * COLUMNS + col] = {attr, ch};
        end
      end
      OP_CLEAR: begin
        wipe_screen();
        cur_x = 0;
        cur_y = 0;
      end
      default: begin
        if (col < COLUMNS && rw < ROWS) begin
          r.cell_word = screen[rw * COLUMNS + col];
        end
      end
    endcase
    r.col  = cur_x[CUR_COL_W-1:0];
    r.line = cur_y[CUR_LINE_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s differs, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare result beats first, then take in register writes and commands
  // accepted at the same edge.
  always @(posedge clk) begin : track
    cursor_report_t want;
    if (rst) begin
      blank_colour = RESET_COLOUR;
      cur_x = 0;
      cur_y = 0;
      wipe_screen();
      predicted_reports.delete();
    end else begin
      if (done) begin
        if (predicted_reports.size() == 0) begin
          $display("%0t ns: result beat with nothing predicted, cell %h cursor %0d,%0d",
                   $time, cell_value, cursor_col, cursor_line);
          mismatches++;
        end else begin
          want = predicted_reports.pop_front();
          check_field("cell_value", want.cell_word, cell_value);
          check_field("cursor_col", 16'(want.col), 16'(cursor_col));
          check_field("cursor_line", 16'(want.line), 16'(cursor_line));
          check_field("scrolled", 16'(want.scr), 16'(scrolled));
        end
        if (scrolled === 1'b1) begin
          scrolls_seen++;
        end
      end
      if (cfg_write_en) begin
        blank_colour = cfg_write_data;
      end
      if (start && !busy) begin
        predicted_reports.push_back(run_command(op_t'(operation), char_code, colour,
                                                column, row));
      end
    end
    fail_count   <= mismatches;
    pending      <= predicted_reports.size();
    scroll_count <= scrolls_seen;
  end

endmodule

/* dv/tb_text_console_writer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer: testbench for the text console writer
// Drives screen commands with random gaps and blank colour settings between
// phases. Directed commands hit the screen corners, out-of-range positions
// and every operation; the random phases print text lines, walk the cursor
// to the bottom so that wraps and newlines scroll, write and read back cells,
// and mix in noise commands. The checker beside the block does all checking.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int PHASE_ITEMS  = 390;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  op_t                   operation;
  logic [CHAR_W-1:0]     char_code;
  logic [COLOUR_W-1:0]   colour;
  logic [CUR_COL_W-1:0]  column;
  logic [CUR_LINE_W-1:0] row;
  logic                  cfg_write_en;
  logic [COLOUR_W-1:0]   cfg_write_data;
  logic                  done;
  logic [CELL_W-1:0]     cell_value;
  logic [CUR_COL_W-1:0]  cursor_col;
  logic [CUR_LINE_W-1:0] cursor_line;
  logic                  scrolled;
  int                    fail_count;
  int                    pending;
  int                    scroll_count;

  // Stimulus bookkeeping; the newline and clear budgets limit the slow
  // scrolls and sweeps that newlines and clears cause.
  int commands_sent;
  int reads_sent;
  int clears_sent;
  int colour_writes;
  int newlines_left;
  int clears_left;
  bit gaps_on;

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (.*);

  console_screen_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung block.
  initial begin
    #(40_000_000);
    $display("FAIL");
    $finish;
  end

  // Any character byte except newline.
  function automatic logic [CHAR_W-1:0] text_char();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(0, 255));
    if (c == NEWLINE_CODE) begin
      c = c + 8'd1;
    end
    return c;
  endfunction

  // Present one command beat, after a random gap at times while gaps are on, and hold it until taken.
  task automatic send_op(input op_t op, input logic [CHAR_W-1:0] ch,
                         input logic [COLOUR_W-1:0] attr,
                         input logic [CUR_COL_W-1:0] col,
                         input logic [CUR_LINE_W-1:0] rw);
    if (gaps_on && $urandom_range(0, 99) < 11) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start     = 1'b1;
    operation = op;
    char_code = ch;
    colour    = attr;
    column    = col;
    row       = rw;
    do @(posedge clk); while (busy);
    commands_sent++;
    if (op == OP_READ) begin
      reads_sent++;
    end
    if (op == OP_CLEAR) begin
      clears_sent++;
    end
  endtask

  // Wait until every predicted report has arrived and the block is idle.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_blank_colour(input logic [COLOUR_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_write_en   = 1'b1;
    cfg_write_data = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
    colour_writes++;
  endtask

  // Clear, then walk the cursor down to the row above the bottom with a
  // little text on each line. A full line at the end wraps into a scroll.
  task automatic clear_and_walk(input bit full_line);
    int r;
    send_op(OP_CLEAR, CHAR_W'($urandom), COLOUR_W'($urandom),
            CUR_COL_W'($urandom), CUR_LINE_W'($urandom));
    for (r = 0; r < ROWS - 2; r++) begin
      repeat ($urandom_range(0, 3)) begin
        send_op(OP_PUT_CURSOR, text_char(), COLOUR_W'($urandom),
                CUR_COL_W'($urandom), CUR_LINE_W'($urandom));
      end
      send_op(OP_PUT_CURSOR, NEWLINE_CODE, COLOUR_W'($urandom),
              CUR_COL_W'($urandom), CUR_LINE_W'($urandom));
    end
    if (full_line) begin
      repeat (COLUMNS) begin
        send_op(OP_PUT_CURSOR, text_char(), COLOUR_W'($urandom),
                CUR_COL_W'($urandom), CUR_LINE_W'($urandom));
      end
    end
  endtask

  // A run of characters at the cursor, mostly ended by a newline.
  task automatic text_run();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 24);
    repeat (len) begin
      send_op(OP_PUT_CURSOR, text_char(), COLOUR_W'($urandom),
              CUR_COL_W'($urandom), CUR_LINE_W'($urandom));
    end
    if (newlines_left > 0 && $urandom_range(0, 9) < 7) begin
      newlines_left--;
      send_op(OP_PUT_CURSOR, NEWLINE_CODE, COLOUR_W'($urandom),
              CUR_COL_W'($urandom), CUR_LINE_W'($urandom));
    end
  endtask

  // Positioned writes, read back in reverse order, plus one read anywhere.
  task automatic write_read_back(input int count);
    logic [CUR_COL_W-1:0]  cols [8];
    logic [CUR_LINE_W-1:0] rows [8];
    int i;
    for (i = 0; i < count; i++) begin
      cols[i] = CUR_COL_W'($urandom_range(0, COLUMNS - 1));
      rows[i] = CUR_LINE_W'($urandom_range(0, ROWS - 1));
      send_op(OP_PUT_POS, CHAR_W'($urandom), COLOUR_W'($urandom), cols[i], rows[i]);
    end
    for (i = count - 1; i >= 0; i--) begin
      send_op(OP_READ, CHAR_W'($urandom), COLOUR_W'($urandom), cols[i], rows[i]);
    end
    send_op(OP_READ, CHAR_W'($urandom), COLOUR_W'($urandom),
            CUR_COL_W'($urandom_range(0, COLUMNS - 1)),
            CUR_LINE_W'($urandom_range(0, ROWS - 1)));
  endtask

  // Random command other than clear; positions span the whole field width.
  task automatic noise_op();
    op_t               op;
    logic [CHAR_W-1:0] ch;
    op = op_t'($urandom_range(0, 3));
    if (op == OP_CLEAR) begin
      op = OP_READ;
    end
    ch = CHAR_W'($urandom_range(0, 255));
    if (op == OP_PUT_CURSOR && ch == NEWLINE_CODE) begin
      if (newlines_left > 0) begin
        newlines_left--;
      end else begin
        ch = ch + 8'd1;
      end
    end
    send_op(op, ch, COLOUR_W'($urandom), CUR_COL_W'($urandom_range(0, 127)),
            CUR_LINE_W'($urandom_range(0, 31)));
  endtask

  // Main stimulus.
  initial begin
    int p;
    int phase_start;
    int pick;
    logic [COLOUR_W-1:0] phase_colour;
    rst            = 1'b1;
    start          = 1'b0;
    operation      = OP_PUT_CURSOR;
    char_code      = '0;
    colour         = '0;
    column         = '0;
    row            = '0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    commands_sent  = 0;
    reads_sent     = 0;
    clears_sent    = 0;
    colour_writes  = 0;
    newlines_left  = 120;
    clears_left    = 3;
    gaps_on        = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset contents, corners, out-of-range positions, every
    // operation, a newline and a newline byte written by position.
    send_op(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_op(OP_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1));
    send_op(OP_READ, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_op(OP_PUT_POS, 8'hFF, 8'hFF, 7'(COLUMNS - 1), 5'(ROWS - 1));
    send_op(OP_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1));
    send_op(OP_PUT_POS, 8'h58, 8'h1E, 7'(COLUMNS), 5'd0);
    send_op(OP_PUT_POS, 8'h58, 8'h1E, 7'd0, 5'(ROWS));
    send_op(OP_READ, 8'h00, 8'h00, 7'(COLUMNS), 5'd0);
    send_op(OP_READ, 8'h00, 8'h00, 7'd0, 5'(ROWS));
    send_op(OP_PUT_CURSOR, 8'h00, 8'h00, 7'd0, 5'd0);
    send_op(OP_PUT_CURSOR, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_op(OP_PUT_CURSOR, NEWLINE_CODE, 8'h47, 7'd0, 5'd0);
    send_op(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_op(OP_READ, 8'h00, 8'h00, 7'd1, 5'd0);
    send_op(OP_PUT_POS, NEWLINE_CODE, 8'hA5, 7'd0, 5'd0);
    send_op(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_op(OP_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
    send_op(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_op(OP_READ, 8'h00, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1));

    // Random phases, each with its own blank colour. The third phase runs
    // without gaps.
    for (p = 0; p < 5; p++) begin
      case (p)
        0:       phase_colour = 8'h00;
        1:       phase_colour = 8'hFF;
        4:       phase_colour = RESET_COLOUR;
        default: phase_colour = COLOUR_W'($urandom_range(0, 255));
      endcase
      set_blank_colour(phase_colour);
      gaps_on     = (p != 2);
      phase_start = commands_sent;
      clear_and_walk(p == 0);
      while (commands_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          text_run();
        end else if (pick < 60) begin
          write_read_back($urandom_range(1, 6));
        end else if (pick < 98 || clears_left == 0) begin
          noise_op();
        end else begin
          clears_left--;
          clear_and_walk(1'b0);
        end
      end
    end

    drain();
    $display("Sent %0d commands: %0d reads, %0d clears, %0d blank colour settings.",
             commands_sent, reads_sent, clears_sent, colour_writes);
    $display("Result beats reported %0d scrolls of the screen.", scroll_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
dv/console_screen_checker.sv
dv/tb_text_console_writer.sv
